>>> rtl/core/twa_pkg.sv
package twa_pkg;

    typedef enum logic [1:0] {
        MODE_UPDATE = 2'd0,
        MODE_SET    = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_WB
    } t_state;

    // datapath step selects from the sequencer
    typedef struct packed {
        logic load;
        logic mul;
        logic prep;
        logic div;
    } t_dp_op;

endpackage

>>> rtl/core/twa_datapath.sv
module twa_datapath
    import twa_pkg::*;
#(
    parameter int SW = 24,
    parameter int TW = 32
) (
    input  logic                 i_clk,
    input  t_dp_op               i_op,
    input  logic [TW-1:0]        i_t1,
    input  logic [TW-1:0]        i_t2,
    input  logic [TW:0]          i_total,
    input  logic signed [SW-1:0] i_avg,
    input  logic signed [SW-1:0] i_sample,
    output logic signed [SW-1:0] o_quotient
);

    localparam int NUMW = TW + SW + 1;

    logic [TW-1:0]   r_t1;
    logic [TW-1:0]   r_t2;
    logic [TW:0]     r_den;
    logic [NUMW-1:0] r_acc;
    logic [TW:0]     r_rem;
    logic [SW-2:0]   r_quo;
    logic            r_neg;

    logic [NUMW-1:0] opa;
    logic [NUMW-1:0] opb;
    logic [NUMW-1:0] opc;
    logic            cin;
    logic [NUMW-1:0] sum;
    logic [NUMW-1:0] mag;
    logic            div_neg;

    // one shared adder: shift-add multiply, then trial subtract for the divide
    always_comb begin
        if (i_op.div) begin
            opa = {{(NUMW-TW-2){1'b0}}, r_rem, r_quo[SW-2]};
            opb = {{(NUMW-TW-3){1'b0}}, ~{2'b00, r_den}};
            opc = '0;
            cin = 1'b1;
        end else begin
            opa = {r_acc[NUMW-2:0], 1'b0};
            opb = r_t1[TW-1] ? {{(NUMW-SW){i_avg[SW-1]}}, i_avg} : '0;
            opc = r_t2[TW-1] ? {{(NUMW-SW){i_sample[SW-1]}}, i_sample} : '0;
            cin = 1'b0;
        end
        sum = opa + opb + opc + {{(NUMW-1){1'b0}}, cin};
    end

    assign div_neg = sum[TW+2];
    // floor(n/d) for n < 0 is ~((~n)/d)
    assign mag     = r_acc[NUMW-1] ? ~r_acc : r_acc;

    always_ff @(posedge i_clk) begin
        if (i_op.load) begin
            r_t1  <= i_t1;
            r_t2  <= i_t2;
            r_den <= i_total;
            r_acc <= '0;
        end else if (i_op.mul) begin
            r_acc <= sum;
            r_t1  <= {r_t1[TW-2:0], 1'b0};
            r_t2  <= {r_t2[TW-2:0], 1'b0};
        end else if (i_op.prep) begin
            // quotient fits SW-1 bits, so the upper dividend part is already below d
            r_rem <= mag[NUMW-2:SW-1];
            r_quo <= mag[SW-2:0];
            r_neg <= r_acc[NUMW-1];
        end else if (i_op.div) begin
            if (div_neg) begin
                r_rem <= {r_rem[TW-1:0], r_quo[SW-2]};
            end else begin
                r_rem <= sum[TW:0];
            end
            r_quo <= {r_quo[SW-3:0], ~div_neg};
        end
    end

    assign o_quotient = r_neg ? ~{1'b0, r_quo} : {1'b0, r_quo};

endmodule

>>> rtl/core/twa_ctrl.sv
module twa_ctrl
    import twa_pkg::*;
#(
    parameter int SW = 24,
    parameter int TW = 32
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  logic   i_need_div,
    input  logic   i_out_free,
    output t_dp_op o_op,
    output logic   o_ready,
    output logic   o_wb
);

    localparam int MAXN = (TW > SW) ? TW : SW;
    localparam int CW   = $clog2(MAXN + 1);

    t_state        r_state;
    t_state        n_state;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_start) n_state = i_need_div ? ST_MUL : ST_WB;
            ST_MUL:  if (r_cnt == CW'(TW - 1)) n_state = ST_PREP;
            ST_PREP: n_state = ST_DIV;
            ST_DIV:  if (r_cnt == CW'(SW - 2)) n_state = ST_WB;
            ST_WB:   if (i_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        if ((r_state == ST_MUL || r_state == ST_DIV) && n_state == r_state) begin
            n_cnt = r_cnt + CW'(1);
        end else begin
            n_cnt = '0;
        end
    end

    always_comb begin
        o_op.load = (r_state == ST_IDLE) && i_start;
        o_op.mul  = (r_state == ST_MUL);
        o_op.prep = (r_state == ST_PREP);
        o_op.div  = (r_state == ST_DIV);
        o_ready   = (r_state == ST_IDLE);
        o_wb      = (r_state == ST_WB) && i_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

>>> rtl/core/time_weighted_average_min_max_core.sv
// Time-weighted average with min/max, one result word per input word.
// An update that needs the divide runs the TW-step shift-add multiply and the
// (SW-1)-step restoring divide on one shared adder before writeback; other
// items go straight to writeback. The result is valid after writeback.
// The next word is taken only after writeback of the last one, and later
// while the output word is stalled.
// Synchronous active-low reset: average 0, min most positive, max most negative,
// no sample held, both timestamps 0; output valid cleared.
module time_weighted_average_min_max_core
    import twa_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 24,
    parameter int TIME_WIDTH   = 32,
    localparam int InW  = ((2 + SAMPLE_WIDTH + TIME_WIDTH + 7) / 8) * 8,
    localparam int OutW = ((3 * SAMPLE_WIDTH + 1 + 7) / 8) * 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [InW-1:0]  s_axis_tdata,  // mode, sample, timestamp
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [OutW-1:0] m_axis_tdata   // average, minimum, maximum, valid_res
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int TW = TIME_WIDTH;

    localparam logic signed [SW-1:0] SMax = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMin = {1'b1, {(SW-1){1'b0}}};

    logic                 in_fire;
    logic [1:0]           in_mode;
    logic signed [SW-1:0] in_sample;
    logic [TW-1:0]        in_ts;
    logic [TW-1:0]        t1;
    logic [TW-1:0]        t2;
    logic [TW:0]          total;
    logic                 need_div;
    logic                 out_free;
    logic                 wb;
    t_dp_op               dp_op;
    logic signed [SW-1:0] quotient;

    // held state
    logic signed [SW-1:0] r_avg, n_avg;
    logic signed [SW-1:0] r_min, n_min;
    logic signed [SW-1:0] r_max, n_max;
    logic                 r_has, n_has;
    logic [TW-1:0]        r_wst, n_wst;
    logic [TW-1:0]        r_lut, n_lut;

    // captured word
    logic [1:0]           r_mode;
    logic signed [SW-1:0] r_smp;
    logic [TW-1:0]        r_ts;
    logic                 r_div;

    logic                 r_m_valid;
    logic [OutW-1:0]      r_m_data;
    logic [OutW-1:0]      n_m_data;

    assign in_mode   = s_axis_tdata[1:0];
    assign in_sample = s_axis_tdata[SW+1:2];
    assign in_ts     = s_axis_tdata[SW+TW+1:SW+2];
    assign in_fire   = s_axis_tvalid && s_axis_tready;

    assign t1       = r_lut - r_wst;
    assign t2       = in_ts - r_lut;
    assign total    = {1'b0, t1} + {1'b0, t2};
    assign need_div = (in_mode == MODE_UPDATE) && r_has && (total != '0);
    assign out_free = !r_m_valid || m_axis_tready;

    twa_ctrl #(
        .SW(SW),
        .TW(TW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_fire),
        .i_need_div (need_div),
        .i_out_free (out_free),
        .o_op       (dp_op),
        .o_ready    (s_axis_tready),
        .o_wb       (wb)
    );

    twa_datapath #(
        .SW(SW),
        .TW(TW)
    ) u_dp (
        .i_clk      (i_clk),
        .i_op       (dp_op),
        .i_t1       (t1),
        .i_t2       (t2),
        .i_total    (total),
        .i_avg      (r_avg),
        .i_sample   (in_fire ? in_sample : r_smp),
        .o_quotient (quotient)
    );

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_mode <= in_mode;
            r_smp  <= in_sample;
            r_ts   <= in_ts;
            r_div  <= need_div;
        end
    end

    always_comb begin
        n_avg = r_avg;
        n_min = r_min;
        n_max = r_max;
        n_has = r_has;
        n_wst = r_wst;
        n_lut = r_lut;
        unique case (r_mode)
            MODE_UPDATE: begin
                n_lut = r_ts;
                if (r_has) begin
                    if (r_div) n_avg = quotient;
                    if (r_smp > r_max) n_max = r_smp;
                    if (r_smp < r_min) n_min = r_smp;
                end else begin
                    n_avg = r_smp;
                    n_min = r_smp;
                    n_max = r_smp;
                    n_has = 1'b1;
                end
            end
            MODE_SET: begin
                n_wst = r_ts;
                n_lut = r_ts;
                n_avg = r_smp;
                n_min = r_smp;
                n_max = r_smp;
                n_has = 1'b1;
            end
            MODE_CLEAR: begin
                n_min = SMax;
                n_max = SMin;
                n_has = 1'b0;
                n_wst = r_ts;
            end
            default: begin
            end
        endcase
        if (n_has) begin
            n_m_data = OutW'({1'b1, n_max, n_min, n_avg});
        end else begin
            n_m_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg     <= '0;
            r_min     <= SMax;
            r_max     <= SMin;
            r_has     <= 1'b0;
            r_wst     <= '0;
            r_lut     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (wb) begin
                r_avg     <= n_avg;
                r_min     <= n_min;
                r_max     <= n_max;
                r_has     <= n_has;
                r_wst     <= n_wst;
                r_lut     <= n_lut;
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wb) begin
            r_m_data <= n_m_data;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

>>> tb/sv/twa_result_checker.sv
`timescale 1ns / 100ps

module twa_result_checker
    import twa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // mode, sample, timestamp
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [79:0] m_axis_tdata,   // average, minimum, maximum, valid_res
    output int          o_errors,
    output int          o_pending,
    output int          o_checked
);

    localparam logic signed [23:0] SMAX = 24'sh7F_FFFF;
    localparam logic signed [23:0] SMIN = 24'sh80_0000;

    // matches the low 73 bits of the result word
    typedef struct packed {
        logic        valid_res;
        logic [23:0] maximum;
        logic [23:0] minimum;
        logic [23:0] average;
    } t_stats;

    logic signed [23:0] avg_q;
    logic signed [23:0] min_q;
    logic signed [23:0] max_q;
    logic               held_q;
    logic [31:0]        win_start_q;
    logic [31:0]        last_upd_q;

    t_stats stats_due[$];

    task automatic clear_tracker();
        avg_q       = '0;
        min_q       = SMAX;
        max_q       = SMIN;
        held_q      = 1'b0;
        win_start_q = '0;
        last_upd_q  = '0;
        stats_due.delete();
    endtask

    // weighted mean of old average over the elapsed window and the new sample
    task automatic fold_sample(input logic signed [23:0] smp, input logic [31:0] ts);
        logic [31:0] d1;
        logic [31:0] d2;
        longint      t1;
        longint      t2;
        longint      total;
        longint      num;
        longint      quo;
        d1    = last_upd_q - win_start_q;
        d2    = ts - last_upd_q;
        t1    = {32'b0, d1};
        t2    = {32'b0, d2};
        total = t1 + t2;
        if (total != 0) begin
            num = t1 * longint'(avg_q) + t2 * longint'(smp);
            quo = num / total;
            if ((num % total) != 0 && num < 0) begin
                quo = quo - 1;
            end
            avg_q = quo[23:0];
        end
        last_upd_q = ts;
        if (smp > max_q) max_q = smp;
        if (smp < min_q) min_q = smp;
    endtask

    task automatic track_word(input logic [63:0] w);
        t_mode              m;
        logic signed [23:0] smp;
        logic [31:0]        ts;
        t_stats             st;
        m   = t_mode'(w[1:0]);
        smp = w[25:2];
        ts  = w[57:26];
        case (m)
            MODE_UPDATE: begin
                if (held_q) begin
                    fold_sample(smp, ts);
                end else begin
                    avg_q      = smp;
                    min_q      = smp;
                    max_q      = smp;
                    last_upd_q = ts;
                    held_q     = 1'b1;
                end
            end
            MODE_SET: begin
                win_start_q = ts;
                last_upd_q  = ts;
                avg_q       = smp;
                min_q       = smp;
                max_q       = smp;
                held_q      = 1'b1;
            end
            MODE_CLEAR: begin
                min_q       = SMAX;
                max_q       = SMIN;
                held_q      = 1'b0;
                win_start_q = ts;
            end
            default: ;
        endcase
        if (held_q) begin
            st = '{valid_res: 1'b1, maximum: max_q, minimum: min_q, average: avg_q};
        end else begin
            st = '0;
        end
        stats_due.push_back(st);
    endtask

    task automatic compare_word(input t_stats got);
        t_stats want;
        if (stats_due.size() == 0) begin
            o_errors++;
            if (o_errors <= 10) begin
                $display("[%0t] unexpected result word %h", $time, got);
            end
        end else begin
            want = stats_due.pop_front();
            if (got.average !== want.average || got.minimum !== want.minimum ||
                got.maximum !== want.maximum || got.valid_res !== want.valid_res) begin
                o_errors++;
                if (o_errors <= 10) begin
                    $display("[%0t] word %0d: exp avg=%h min=%h max=%h vld=%b",
                             $time, o_checked, want.average, want.minimum,
                             want.maximum, want.valid_res);
                    $display("[%0t] word %0d: got avg=%h min=%h max=%h vld=%b",
                             $time, o_checked, got.average, got.minimum,
                             got.maximum, got.valid_res);
                end
            end
        end
        o_checked++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_tracker();
        end else begin
            if (s_axis_tvalid && s_axis_tready) track_word(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) compare_word(t_stats'(m_axis_tdata[72:0]));
        end
        o_pending = stats_due.size();
    end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import twa_pkg::*;

    localparam logic signed [23:0] SMAX = 24'sh7F_FFFF;
    localparam logic signed [23:0] SMIN = 24'sh80_0000;
    localparam int RUN_ITEMS = 1200;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 80;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // mode, sample, timestamp
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;        // average, minimum, maximum, valid_res

    int errors;
    int pending;
    int checked;
    int cycle_count = 0;
    bit calm = 1'b0;

    int n_update = 0;
    int n_set = 0;
    int n_clear = 0;
    int n_ignored = 0;
    logic [31:0] now_ts = '0;

    always #1 i_clk = ~i_clk;

    time_weighted_average_min_max_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    twa_result_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    always @(negedge i_clk) begin
        m_axis_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 30);
    end

    task automatic send_item(input t_mode m, input logic signed [23:0] smp,
                             input logic [31:0] ts);
        int gap;
        gap = 0;
        if (!calm) begin
            // mostly short random gaps, now and then a long one
            if ($urandom_range(0, 99) < 4) begin
                gap = $urandom_range(1, 70);
            end else begin
                while ($urandom_range(0, 99) < 30) gap++;
            end
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, ts, smp, m};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        case (m)
            MODE_UPDATE: n_update++;
            MODE_SET:    n_set++;
            MODE_CLEAR:  n_clear++;
            default:     n_ignored++;
        endcase
    endtask

    function automatic logic [23:0] pick_sample();
        case ($urandom_range(0, 19))
            0:       return SMAX;
            1:       return SMIN;
            2:       return '0;
            3:       return '1;
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic logic [31:0] next_stamp(input logic [31:0] cur);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)      return cur + $urandom_range(1, 50);
        else if (r < 80) return cur;
        else if (r < 95) return cur + $urandom_range(0, 100000);
        else             return cur + $urandom();
    endfunction

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin : stimulus
        int r;
        t_mode m;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // first sample after reset seeds, then weighted updates
        send_item(MODE_UPDATE, SMAX, 32'd100);
        send_item(MODE_UPDATE, SMIN, 32'd150);
        send_item(MODE_UPDATE, SMAX, 32'd150);       // no new time, old weight only
        send_item(MODE_NONE, 24'sd5, 32'd160);
        send_item(MODE_SET, -24'sd5, 32'd1000);
        send_item(MODE_UPDATE, 24'sd77, 32'd1000);   // zero elapsed: average held
        send_item(MODE_UPDATE, -24'sd1000, 32'd1003); // negative quotient, no remainder
        send_item(MODE_UPDATE, 24'sd3, 32'd1010);
        send_item(MODE_CLEAR, 24'sd0, 32'd2000);
        send_item(MODE_NONE, SMAX, 32'd2001);        // empty: all fields zero
        send_item(MODE_UPDATE, SMIN, 32'd2000);
        send_item(MODE_SET, SMAX, 32'hFFFF_FFF0);
        send_item(MODE_UPDATE, SMIN, 32'h0000_0010); // timestamp wraps
        send_item(MODE_UPDATE, 24'sd1, 32'hFFFF_FFFF);
        send_item(MODE_CLEAR, '1, 32'hFFFF_FFFF);
        send_item(MODE_CLEAR, 24'sd0, 32'd5);        // clear while empty
        send_item(MODE_SET, 24'sd0, 32'd0);
        send_item(MODE_UPDATE, SMAX, 32'hFFFF_FFFF);
        send_item(MODE_UPDATE, SMIN, 32'hFFFF_FFFE); // both spans near 2^32
        send_item(MODE_UPDATE, '1, 32'h0000_0005);
        send_item(MODE_SET, SMIN, 32'h8000_0000);
        send_item(MODE_UPDATE, SMIN, 32'h8000_0000);
        send_item(MODE_UPDATE, SMAX, 32'h8000_0001);
        now_ts = 32'h8000_0001;

        while (n_update + n_set + n_clear < RUN_ITEMS + 20) begin
            calm = (n_update > 450 && n_update < 650);
            r = $urandom_range(0, 99);
            if (r < 80)      m = MODE_UPDATE;
            else if (r < 88) m = MODE_SET;
            else if (r < 94) m = MODE_CLEAR;
            else if (r < 97) m = MODE_NONE;
            else             m = MODE_UPDATE;
            if (r >= 97) begin
                // stray stamp, breaks the time order
                send_item(m, pick_sample(), $urandom());
            end else begin
                now_ts = next_stamp(now_ts);
                send_item(m, pick_sample(), now_ts);
            end
        end
        s_axis_tvalid <= 1'b0;
        calm = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("covered %0d updates, %0d restarts, %0d clears, %0d unused-mode words",
                 n_update, n_set, n_clear, n_ignored);
        $display("%0d result words checked, %0d mismatches, %0d cycles",
                 checked, errors, cycle_count);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> time_weighted_average_min_max_core.f
rtl/core/twa_pkg.sv
rtl/core/twa_datapath.sv
rtl/core/twa_ctrl.sv
rtl/core/time_weighted_average_min_max_core.sv
tb/sv/twa_result_checker.sv
tb/sv/tb.sv
